/* sv/stereo_waveform_generator_unit_macros.svh */
// ----------------------------------------------------------------------------
// stereo waveform generator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef STEREO_WAVEFORM_GENERATOR_UNIT_MACROS_SVH
`define STEREO_WAVEFORM_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define SWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define SWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/swg_pkg.sv */
// ----------------------------------------------------------------------------
// swg_pkg
// shared types and constants of the stereo waveform generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swg_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int STEP_W       = 32;
  localparam int AMP_W        = 15;
  localparam int WAVE_W       = 3;
  localparam int LFSR_W       = 16;
  localparam int NOISE_W      = 15;
  localparam int MAG_W        = 16;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd9739156;
  localparam logic [LFSR_W-1:0] LFSR_SEED        = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS        = 16'hB400;
  localparam longint unsigned   HALF_PI_Q30      = 64'd1686629713;
  localparam longint unsigned   Q15_ONE          = 64'd32768;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SIN   = 3'd0,
    WAVE_SQR   = 3'd1,
    WAVE_SAW   = 3'd2,
    WAVE_TRI   = 3'd3,
    WAVE_NOISE = 3'd4
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_WAVEFORM     = 3'd1,
    REG_PEAK_AMP     = 3'd2,
    REG_CHANNEL_MASK = 3'd3,
    REG_BIG_ENDIAN   = 3'd4
  } cfg_reg_t;

  // shaped waveform value, sign and magnitude, ahead of scaling
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             use_rom;
    logic [MAG_W-1:0] mag;
  } shape_t;

endpackage

/* sv/swg_phase.sv */
// ----------------------------------------------------------------------------
// swg_phase
// phase accumulator and noise lfsr, first pipeline register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_waveform_generator_unit_macros.svh"

module swg_phase #(
  parameter int PHASE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        in_accept,
  input  logic                        request,
  input  logic                        restart,
  input  logic [swg_pkg::STEP_W-1:0]  phase_step,
  input  logic [swg_pkg::WAVE_W-1:0]  waveform,
  output logic                        s1_valid,
  output logic [PHASE_BITS-1:0]       s1_phase,
  output logic [swg_pkg::NOISE_W-1:0] s1_noise
);
  import swg_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] step_ext;
  logic [LFSR_W-1:0]     lfsr_r, lfsr_nxt;
  logic [LFSR_W-1:0]     lfsr_step;
  logic                  is_noise;
  logic                  s1_valid_r;
  logic [PHASE_BITS-1:0] s1_phase_r;
  logic [NOISE_W-1:0]    s1_noise_r;

  assign step_ext  = PHASE_BITS'(phase_step);
  assign phase_cur = restart ? '0 : phase_r;
  assign is_noise  = (waveform >= WAVE_NOISE);
  assign lfsr_step = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  always_comb begin
    phase_nxt = phase_r;
    lfsr_nxt  = lfsr_r;
    if (in_accept) begin
      phase_nxt = request ? phase_cur + step_ext : phase_cur;
      if (request && is_noise) begin
        lfsr_nxt = lfsr_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      lfsr_r     <= LFSR_SEED;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      lfsr_r  <= lfsr_nxt;
      if (advance) begin
        s1_valid_r <= in_accept && request;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_phase_r <= phase_cur;
      s1_noise_r <= lfsr_step[LFSR_W-1:1];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_phase = s1_phase_r;
  assign s1_noise = s1_noise_r;

  `SWG_ASSERT_NEXT(a_restart_clears, clk, rst_n, in_accept && restart && !request, phase_r == '0, "restart did not clear phase")
  `SWG_ASSERT_NEXT(a_phase_advance, clk, rst_n, in_accept && request && !restart, phase_r == PHASE_BITS'($past(phase_r) + $past(step_ext)), "phase did not advance by step")
  `SWG_ASSERT_NOW(a_lfsr_live, clk, rst_n, 1'b1, lfsr_r != '0, "noise lfsr locked at zero")

endmodule

/* sv/swg_wave.sv */
// ----------------------------------------------------------------------------
// swg_wave
// waveform shaping and quarter-wave sine rom, second pipeline register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swg_wave #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        s1_valid,
  input  logic [PHASE_BITS-1:0]       s1_phase,
  input  logic [swg_pkg::NOISE_W-1:0] s1_noise,
  input  logic [swg_pkg::WAVE_W-1:0]  waveform,
  output swg_pkg::shape_t             s2,
  output logic [swg_pkg::MAG_W-1:0]   rom_q
);
  import swg_pkg::*;

  localparam int IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FracW = PHASE_BITS - 2;
  localparam int ProdW = FracW + IdxW;

  // q30 taylor series of sin(x), terms truncated, rounded half up to q15
  function automatic logic [MAG_W-1:0] sine_q15(input logic [63:0] x);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    t = x;
    s = x;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 6;   s = (s >= t) ? s - t : 64'd0;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 20;  s = s + t;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 42;  s = (s >= t) ? s - t : 64'd0;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 72;  s = s + t;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 110; s = (s >= t) ? s - t : 64'd0;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 156; s = s + t;
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 210; s = (s >= t) ? s - t : 64'd0;
    r = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (r > Q15_ONE) begin
      r = Q15_ONE;
    end
    return r[MAG_W-1:0];
  endfunction

  logic [MAG_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] SinX = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = sine_q15(SinX);
  end

  logic [1:0]        quad;
  logic [FracW-1:0]  frac;
  logic [ProdW-1:0]  idx_prod;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   addr;
  logic [15:0]       u;
  logic signed [18:0] u_s;
  logic signed [18:0] v;
  logic signed [18:0] v_abs;
  shape_t            shape;
  shape_t            s2_r;
  logic [MAG_W-1:0]  rom_q_r;

  assign quad     = s1_phase[PHASE_BITS-1 -: 2];
  assign frac     = s1_phase[FracW-1:0];
  assign idx_prod = ProdW'(frac) * ProdW'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[ProdW-1 -: IdxW];
  // odd quadrants run the table backwards
  assign addr     = quad[0] ? IdxW'(SINE_TABLE_DEPTH) - idx : idx;
  assign u        = s1_phase[PHASE_BITS-1 -: 16];
  assign u_s      = $signed({3'b000, u});

  always_comb begin
    unique case (waveform)
      WAVE_SIN: v = '0;
      WAVE_SQR: v = u[15] ? -19'sd32768 : 19'sd32768;
      WAVE_SAW: v = u_s - 19'sd32768;
      WAVE_TRI: v = u[15] ? 19'sd98304 - (u_s <<< 1) : (u_s <<< 1) - 19'sd32768;
      default:  v = $signed({4'b0000, s1_noise});
    endcase
  end

  assign v_abs = v[18] ? -v : v;

  always_comb begin
    shape.valid   = s1_valid;
    shape.use_rom = (waveform == WAVE_SIN);
    shape.neg     = shape.use_rom ? quad[1] : v[18];
    shape.mag     = v_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (advance) begin
      s2_r.valid <= shape.valid;
    end
    if (advance) begin
      s2_r.neg     <= shape.neg;
      s2_r.use_rom <= shape.use_rom;
      s2_r.mag     <= shape.mag;
      rom_q_r      <= sine_rom[addr];
    end
  end

  assign s2    = s2_r;
  assign rom_q = rom_q_r;

endmodule

/* sv/swg_out.sv */
// ----------------------------------------------------------------------------
// swg_out
// amplitude scaling, channel mask and frame packing into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swg_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  swg_pkg::shape_t                s2,
  input  logic [swg_pkg::MAG_W-1:0]      rom_q,
  input  logic [swg_pkg::AMP_W-1:0]      peak_amplitude,
  input  logic [1:0]                     channel_mask,
  input  logic                           big_endian,
  output logic                           out_valid,
  output logic [swg_pkg::OUT_DATA_W-1:0] out_data
);
  import swg_pkg::*;

  logic [MAG_W-1:0]       mag;
  logic [30:0]            prod;
  logic [AMP_W-1:0]       scaled;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] left;
  logic [SAMPLE_BITS-1:0] right;
  logic [31:0]            frame;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  assign mag    = s2.use_rom ? rom_q : s2.mag;
  assign prod   = 31'(mag) * 31'(peak_amplitude);
  // truncation toward zero: scale the magnitude, then restore the sign
  assign scaled = prod[29:15];
  assign smp    = s2.neg ? 16'd0 - {1'b0, scaled} : {1'b0, scaled};
  assign left   = channel_mask[0] ? smp : '0;
  assign right  = channel_mask[1] ? smp : '0;
  assign frame  = big_endian ? {right[7:0], right[15:8], left[7:0], left[15:8]}
                             : {right, left};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {frame, right, left};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/stereo_waveform_generator_unit.sv */
// ----------------------------------------------------------------------------
// stereo_waveform_generator_unit
// an item passes the stage one, stage two and output registers in turn to out_tvalid
// throughput: one item per cycle while frames are taken, three register stages with no feedback
// all stages stall together while out_tvalid is high and not taken
// synchronous active-low reset: register defaults, zero phase, lfsr seed,
//   empty pipeline; nothing else needs clearing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_waveform_generator_unit_macros.svh"

module stereo_waveform_generator_unit #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [swg_pkg::IN_DATA_W-1:0]  in_tdata,   // request, restart, zero pad
  // frame stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [swg_pkg::OUT_DATA_W-1:0] out_tdata,  // left_sample, right_sample, frame_word
  // register writes
  input  logic                           cfg_wr_en,
  input  logic [swg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import swg_pkg::*;

  // configuration registers
  logic [STEP_W-1:0] phase_step_r;
  logic [WAVE_W-1:0] waveform_r;
  logic [AMP_W-1:0]  peak_amp_r;
  logic [1:0]        channel_mask_r;
  logic              big_endian_r;

  // pipeline control: every stage moves when the output register is free
  logic advance;
  logic in_accept;

  // stage one: phase used for this item and its noise value
  logic                  s1_valid;
  logic [PHASE_BITS-1:0] s1_phase;
  logic [NOISE_W-1:0]    s1_noise;

  // stage two: shaped value plus sine rom read
  shape_t           s2;
  logic [MAG_W-1:0] rom_q;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;
  assign in_accept = in_tvalid && advance;

  // register writes, to be made only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RESET;
      waveform_r     <= WAVE_SIN;
      peak_amp_r     <= '0;
      channel_mask_r <= '0;
      big_endian_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_WAVEFORM:     waveform_r     <= cfg_wdata[WAVE_W-1:0];
        REG_PEAK_AMP:     peak_amp_r     <= cfg_wdata[AMP_W-1:0];
        REG_CHANNEL_MASK: channel_mask_r <= cfg_wdata[1:0];
        REG_BIG_ENDIAN:   big_endian_r   <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // phase accumulator and lfsr; restart clears the phase even without request
  swg_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_accept  (in_accept),
    .request    (in_tdata[0]),
    .restart    (in_tdata[1]),
    .phase_step (phase_step_r),
    .waveform   (waveform_r),
    .s1_valid   (s1_valid),
    .s1_phase   (s1_phase),
    .s1_noise   (s1_noise)
  );

  // waveform value in sign-magnitude q1.15, sine from the quarter-wave rom
  swg_wave #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_phase (s1_phase),
    .s1_noise (s1_noise),
    .waveform (waveform_r),
    .s2       (s2),
    .rom_q    (rom_q)
  );

  // peak scaling, channel mask and byte order into the output register
  swg_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .s2             (s2),
    .rom_q          (rom_q),
    .peak_amplitude (peak_amp_r),
    .channel_mask   (channel_mask_r),
    .big_endian     (big_endian_r),
    .out_valid      (out_tvalid),
    .out_data       (out_tdata)
  );

  // masked channels read as silence
  `SWG_ASSERT_NOW(a_left_masked, clk, rst_n, out_tvalid && !channel_mask_r[0], out_tdata[15:0] == 16'h0000, "inactive left channel not zero")
  // scaling truncates toward zero, so full negative scale never appears
  `SWG_ASSERT_NOW(a_no_neg_full, clk, rst_n, out_tvalid, out_tdata[15:0] != 16'h8000 && out_tdata[31:16] != 16'h8000, "sample reached negative full scale")
  // little-endian frame is the two samples as they stand
  `SWG_ASSERT_NOW(a_le_frame, clk, rst_n, out_tvalid && !big_endian_r, out_tdata[63:32] == out_tdata[31:0], "little-endian frame disagrees with samples")

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stereo waveform generator: a queue of request
// items and register writes feeds a clocked driver, a clocked monitor with
// random back-pressure compares every frame with a bit-exact predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import swg_pkg::*;

  localparam int SINE_DEPTH     = 256;
  localparam int Q15_FULL       = 32768;
  localparam int SETTLE_CYCLES  = 6;     // pipeline is three deep
  localparam int TAIL_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REQUEST_TARGET = 800;
  localparam int MAX_WAIT       = 11;

  // waveform codes past noise still select noise
  localparam logic [WAVE_W-1:0] WAVE_SPARE = 3'd7;

  typedef enum logic [1:0] {
    JOB_REQ,    // one item on the request stream
    JOB_REG,    // one register write, issued once the pipeline is empty
    JOB_DRAIN   // sender holds off until every frame has come back
  } job_kind_t;

  typedef struct {
    job_kind_t              kind;
    logic [IN_DATA_W-1:0]   data;
    cfg_reg_t               idx;
    logic [CFG_DATA_W-1:0]  val;
  } job_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [31:0] word;
  } frame_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;   // request, restart, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;         // left_sample, right_sample, frame_word
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  stereo_waveform_generator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: own copy of registers, phase accumulator and noise lfsr
  // --------------------------------------------------------------------------
  logic [15:0]         sine_q15 [0:SINE_DEPTH];
  logic [STEP_W-1:0]   step_cfg;
  logic [WAVE_W-1:0]   wave_sel;
  logic [AMP_W-1:0]    amp_cfg;
  logic [1:0]          mask_cfg;
  logic                be_cfg;
  logic [31:0]         phase_acc;
  logic [LFSR_W-1:0]   lfsr_q;

  frame_t expected_frames [$];
  job_t   pending [$];
  int     errors = 0;

  // quarter-wave sine in q15, q30 taylor series up to the x^15 term
  function automatic void fill_quarter_wave();
    longint unsigned x, t, s, r;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
      t = x;
      s = x;
      for (int n = 1; n <= 7; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1)
          s = (s >= t) ? s - t : 64'd0;
        else
          s = s + t;
      end
      r = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (r > 64'(Q15_FULL))
        r = 64'(Q15_FULL);
      sine_q15[k] = r[15:0];
    end
  endfunction

  function automatic void reset_model();
    step_cfg  = PHASE_STEP_RESET;
    wave_sel  = WAVE_SIN;
    amp_cfg   = '0;
    mask_cfg  = '0;
    be_cfg    = 1'b0;
    phase_acc = '0;
    lfsr_q    = LFSR_SEED;
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_PHASE_STEP:   step_cfg = val[STEP_W-1:0];
      REG_WAVEFORM:     wave_sel = val[WAVE_W-1:0];
      REG_PEAK_AMP:     amp_cfg  = val[AMP_W-1:0];
      REG_CHANNEL_MASK: mask_cfg = val[1:0];
      REG_BIG_ENDIAN:   be_cfg   = val[0];
      default: ;
    endcase
  endfunction

  // one accepted request item: restart, then at most one stereo frame
  function automatic void synth_frame(input logic [IN_DATA_W-1:0] d);
    int              v, m;
    longint unsigned idx, mag;
    logic [15:0]     u, smp;
    logic            lsb;
    frame_t          f;
    if (d[1])
      phase_acc = '0;
    if (!d[0])
      return;
    u = phase_acc[31:16];
    case (wave_sel)
      WAVE_SIN: begin
        idx = (64'(phase_acc[29:0]) * 64'(SINE_DEPTH)) >> 30;
        if (idx > 64'(SINE_DEPTH))
          idx = 64'(SINE_DEPTH);
        m = phase_acc[30] ? int'(sine_q15[SINE_DEPTH - idx]) : int'(sine_q15[idx]);
        v = phase_acc[31] ? -m : m;
      end
      WAVE_SQR: v = phase_acc[31] ? -Q15_FULL : Q15_FULL;
      WAVE_SAW: v = int'(u) - Q15_FULL;
      WAVE_TRI: v = (u < 16'h8000) ? 2 * int'(u) - Q15_FULL : 3 * Q15_FULL - 2 * int'(u);
      default: begin
        // galois lfsr steps once per frame, value kept non-negative
        lsb    = lfsr_q[0];
        lfsr_q = lfsr_q >> 1;
        if (lsb)
          lfsr_q = lfsr_q ^ LFSR_TAPS;
        v = int'(lfsr_q >> 1);
      end
    endcase
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = (mag * 64'(amp_cfg)) >> 15;
    smp = (v < 0) ? -mag[15:0] : mag[15:0];
    f.left  = mask_cfg[0] ? smp : 16'd0;
    f.right = mask_cfg[1] ? smp : 16'd0;
    f.word  = be_cfg ? {f.right[7:0], f.right[15:8], f.left[7:0], f.left[15:8]}
                     : {f.right, f.left};
    expected_frames.push_back(f);
    phase_acc = phase_acc + step_cfg;
  endfunction

  function automatic int draw_wait(input logic burst);
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // --------------------------------------------------------------------------
  // driver: request items and register writes from the pending queue
  // --------------------------------------------------------------------------
  int                    tx_gap;
  int                    settle_cnt;
  logic                  tx_burst;
  logic                  nxt_valid;
  logic [IN_DATA_W-1:0]  nxt_data;
  logic                  nxt_we;
  logic [CFG_IDX_W-1:0]  nxt_idx;
  logic [CFG_DATA_W-1:0] nxt_wdata;
  job_t                  job;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      cfg_wr_en  <= 1'b0;
      cfg_index  <= REG_PHASE_STEP;
      cfg_wdata  <= '0;
      tx_gap     = 0;
      settle_cnt = 0;
      tx_burst   = 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      nxt_data  = in_tdata;
      nxt_we    = 1'b0;
      nxt_idx   = cfg_index;
      nxt_wdata = cfg_wdata;
      if (in_tvalid && in_tready) begin
        synth_frame(in_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending.size() > 0) begin
        job = pending[0];
        if (job.kind == JOB_REQ) begin
          if (tx_gap > 0) begin
            tx_gap--;
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = job.data;
            void'(pending.pop_front());
            // occasionally switch between back-to-back and gappy sending
            if ($urandom_range(0, 39) == 0)
              tx_burst = !tx_burst;
            tx_gap = draw_wait(tx_burst);
          end
        end else if (expected_frames.size() != 0) begin
          settle_cnt = 0;
        end else if (settle_cnt < SETTLE_CYCLES) begin
          // a request-less item may still be in flight
          settle_cnt++;
        end else begin
          settle_cnt = 0;
          void'(pending.pop_front());
          if (job.kind == JOB_REG) begin
            nxt_we    = 1'b1;
            nxt_idx   = job.idx;
            nxt_wdata = job.val;
            apply_reg(job.idx, job.val);
          end
        end
      end
      in_tvalid <= nxt_valid;
      in_tdata  <= nxt_data;
      cfg_wr_en <= nxt_we;
      cfg_index <= nxt_idx;
      cfg_wdata <= nxt_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random stalls on the frame stream, field-by-field compare
  // --------------------------------------------------------------------------
  int     rx_wait;
  logic   rx_burst;
  frame_t got;
  frame_t want;

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    = 0;
      rx_burst   = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.left  = out_tdata[15:0];
        got.right = out_tdata[31:16];
        got.word  = out_tdata[63:32];
        if (expected_frames.size() == 0) begin
          $error("frame %h with no item outstanding", out_tdata);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          check_field("left_sample", 32'(want.left), 32'(got.left));
          check_field("right_sample", 32'(want.right), 32'(got.right));
          check_field("frame_word", want.word, got.word);
        end
        if ($urandom_range(0, 39) == 0)
          rx_burst = !rx_burst;
        rx_wait = draw_wait(rx_burst);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);
    end
  end

  // watchdog: too long without any item moving on either stream
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int req_count = 0;

  function automatic void push_req(input logic req, input logic restart);
    job_t j;
    j.kind = JOB_REQ;
    j.data = '0;
    j.data[0] = req;
    j.data[1] = restart;
    j.idx  = REG_PHASE_STEP;
    j.val  = '0;
    pending.push_back(j);
    if (req)
      req_count++;
  endfunction

  function automatic void push_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    job_t j;
    j.kind = JOB_REG;
    j.data = '0;
    j.idx  = idx;
    j.val  = val;
    pending.push_back(j);
  endfunction

  function automatic void push_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.data = '0;
    j.idx  = REG_PHASE_STEP;
    j.val  = '0;
    pending.push_back(j);
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] val;
    int                    n_items;
    int                    pick;

    fill_quarter_wave();
    reset_model();

    // reset defaults: mask and amplitude zero give silent frames
    push_req(1'b1, 1'b0);
    push_req(1'b1, 1'b0);
    push_req(1'b0, 1'b1);              // restart alone, no frame

    // sine at the four quadrant boundaries, full scale, both channels
    push_reg(REG_PEAK_AMP, 32'd32767);
    push_reg(REG_CHANNEL_MASK, 32'd3);
    push_reg(REG_BIG_ENDIAN, 32'd0);
    push_reg(REG_WAVEFORM, 32'(WAVE_SIN));
    push_reg(REG_PHASE_STEP, 32'h4000_0000);
    push_req(1'b1, 1'b1);
    repeat (4) push_req(1'b1, 1'b0);
    push_drain();

    // square with the largest step
    push_reg(REG_WAVEFORM, 32'(WAVE_SQR));
    push_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    push_req(1'b1, 1'b1);
    push_req(1'b1, 1'b0);

    push_reg(REG_WAVEFORM, 32'(WAVE_SAW));
    push_req(1'b1, 1'b1);
    push_req(1'b1, 1'b0);

    // triangle on both sides of its peak
    push_reg(REG_WAVEFORM, 32'(WAVE_TRI));
    push_reg(REG_PHASE_STEP, 32'h8000_0000);
    push_req(1'b1, 1'b1);
    push_req(1'b1, 1'b0);

    push_reg(REG_WAVEFORM, 32'(WAVE_NOISE));
    push_req(1'b1, 1'b0);
    push_req(1'b1, 1'b0);

    // spare waveform code falls back to noise
    push_reg(REG_WAVEFORM, 32'(WAVE_SPARE));
    push_req(1'b1, 1'b0);
    push_req(1'b0, 1'b0);              // no request, no restart

    // big-endian packing with one channel masked off each way
    push_reg(REG_BIG_ENDIAN, 32'd1);
    push_reg(REG_CHANNEL_MASK, 32'd1);
    push_reg(REG_WAVEFORM, 32'(WAVE_SAW));
    push_reg(REG_PHASE_STEP, 32'h1234_5678);
    push_req(1'b1, 1'b1);
    push_req(1'b1, 1'b0);
    push_reg(REG_CHANNEL_MASK, 32'd2);
    push_req(1'b1, 1'b0);

    // random phases: fresh settings, then a run of request items
    while (req_count < REQUEST_TARGET) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0:       val = '0;
          1:       val = '1;
          2:       val = $urandom_range(0, 65535);
          3:       val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        push_reg(REG_PHASE_STEP, val);
      end
      if ($urandom_range(0, 1))
        push_reg(REG_WAVEFORM, $urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       val = '0;
          1:       val = 32'd32767;
          default: val = $urandom_range(0, 32767);
        endcase
        push_reg(REG_PEAK_AMP, val);
      end
      if ($urandom_range(0, 1))
        push_reg(REG_CHANNEL_MASK, $urandom_range(0, 3));
      if ($urandom_range(0, 1))
        push_reg(REG_BIG_ENDIAN, $urandom_range(0, 1));
      n_items = $urandom_range(10, 60);
      repeat (n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          push_req(1'b0, 1'($urandom_range(0, 1)));
        else if (pick < 10)
          push_req(1'b1, 1'b1);
        else
          push_req(1'b1, 1'b0);
        if ($urandom_range(0, 99) == 0)
          push_drain();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_frames.size() != 0) begin
      $error("%0d frames never arrived", expected_frames.size());
      errors++;
    end
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
